>>> hdl/ccts_pkg.sv
// shared widths and constants for the cycle count timestamp split unit
package ccts_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CycleW  = 64;
  localparam int unsigned FreqW   = 10;
  localparam int unsigned SecW    = 48;
  localparam int unsigned SubW    = 10;
  localparam int unsigned UsRemW  = 20;

  localparam logic [FreqW-1:0]  FreqResetMhz = FreqW'(168);
  localparam logic [UsRemW:0]   UsPerS       = (UsRemW+1)'(1000000);
  localparam logic [SubW:0]     UsPerMs      = (SubW+1)'(1000);
  localparam logic [SubW-1:0]   SubMax       = SubW'(999);

endpackage

>>> hdl/cycle_count_timestamp_split_unit.sv
// cycle counter wrap extension and seconds / ms / us split, bit-serial dividers
//
//   channel  signals                              beat
//   in       in_valid_i  in_ready_o               counter_sample_i
//   out      out_valid_o out_ready_i              seconds_o milliseconds_o
//                                                 microseconds_o total_microseconds_o
//   cfg      cfg_valid_i cfg_ready_o              cpu_freq_mhz_i
//
// one beat in flight: the chained divide by mhz and by one million (one quotient bit
// per cycle) in div, then the divide by one thousand in split, then done hands the
// result over to the output register; no new input beat is taken before idle.
// the output register holds a result while the next beat is already in work; a result
// that is not taken keeps the next beat waiting in done with the input closed.
// reset sets the clock register to 168 mhz and clears sample and wrap count.
module cycle_count_timestamp_split_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ccts_pkg::SampleW-1:0]  counter_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ccts_pkg::SecW-1:0]     seconds_o,
  output logic [ccts_pkg::SubW-1:0]     milliseconds_o,
  output logic [ccts_pkg::SubW-1:0]     microseconds_o,
  output logic [ccts_pkg::CycleW-1:0]   total_microseconds_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ccts_pkg::FreqW-1:0]    cpu_freq_mhz_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StSplit = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  localparam logic [5:0] DivLast   = 6'(ccts_pkg::CycleW - 1);
  localparam logic [5:0] SplitLast = 6'(ccts_pkg::UsRemW - 1);

  logic [1:0]                      state_q, state_d;
  logic [5:0]                      cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic [ccts_pkg::FreqW-1:0]      freq_q, freq_d;
  logic [ccts_pkg::SampleW-1:0]    last_q, last_d;
  logic [ccts_pkg::SampleW-1:0]    wrap_q, wrap_d;

  logic [ccts_pkg::CycleW-1:0]     cyc_q, cyc_d;
  logic [ccts_pkg::CycleW-1:0]     total_q, total_d;
  logic [ccts_pkg::SecW-1:0]       secs_q, secs_d;
  logic [ccts_pkg::FreqW-1:0]      r1_q, r1_d;
  logic [ccts_pkg::UsRemW-1:0]     r2_q, r2_d;
  logic [ccts_pkg::SubW-1:0]       r3_q, r3_d;
  logic [ccts_pkg::SubW-1:0]       ms_q, ms_d;

  logic [ccts_pkg::SecW-1:0]       o_secs_q, o_secs_d;
  logic [ccts_pkg::SubW-1:0]       o_ms_q, o_ms_d;
  logic [ccts_pkg::SubW-1:0]       o_us_q, o_us_d;
  logic [ccts_pkg::CycleW-1:0]     o_total_q, o_total_d;

  logic                            in_fire, cfg_fire, load_out;
  logic [ccts_pkg::FreqW:0]        t1;
  logic                            ge1;
  logic [ccts_pkg::UsRemW:0]       t2;
  logic                            ge2;
  logic [ccts_pkg::SubW:0]         t3;
  logic                            ge3;
  logic [ccts_pkg::SampleW-1:0]    wrap_next;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign load_out    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign out_valid_o          = out_valid_q;
  assign seconds_o            = o_secs_q;
  assign milliseconds_o       = o_ms_q;
  assign microseconds_o       = o_us_q;
  assign total_microseconds_o = o_total_q;

  // one step of each serial divider
  assign t1  = {r1_q, cyc_q[ccts_pkg::CycleW-1]};
  assign ge1 = t1 >= {1'b0, freq_q};
  assign t2  = {r2_q, ge1};
  assign ge2 = t2 >= ccts_pkg::UsPerS;
  assign t3  = {r3_q, r2_q[ccts_pkg::UsRemW-1]};
  assign ge3 = t3 >= ccts_pkg::UsPerMs;

  assign wrap_next = (counter_sample_i < last_q) ? wrap_q + 1'b1 : wrap_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    freq_d      = freq_q;
    last_d      = last_q;
    wrap_d      = wrap_q;
    cyc_d       = cyc_q;
    total_d     = total_q;
    secs_d      = secs_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    r3_d        = r3_q;
    ms_d        = ms_q;
    o_secs_d    = o_secs_q;
    o_ms_d      = o_ms_q;
    o_us_d      = o_us_q;
    o_total_d   = o_total_q;

    if (cfg_fire && (cpu_freq_mhz_i != '0)) begin
      freq_d = cpu_freq_mhz_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          wrap_d  = wrap_next;
          last_d  = counter_sample_i;
          cyc_d   = {wrap_next, counter_sample_i};
          r1_d    = '0;
          r2_d    = '0;
          r3_d    = '0;
          cnt_d   = DivLast;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cyc_d   = {cyc_q[ccts_pkg::CycleW-2:0], 1'b0};
        r1_d    = ge1 ? ccts_pkg::FreqW'(t1 - {1'b0, freq_q})
                      : ccts_pkg::FreqW'(t1);
        total_d = {total_q[ccts_pkg::CycleW-2:0], ge1};
        r2_d    = ge2 ? ccts_pkg::UsRemW'(t2 - ccts_pkg::UsPerS)
                      : ccts_pkg::UsRemW'(t2);
        secs_d  = {secs_q[ccts_pkg::SecW-2:0], ge2};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = SplitLast;
          state_d = StSplit;
        end
      end
      StSplit: begin
        r2_d  = {r2_q[ccts_pkg::UsRemW-2:0], 1'b0};
        r3_d  = ge3 ? ccts_pkg::SubW'(t3 - ccts_pkg::UsPerMs)
                    : ccts_pkg::SubW'(t3);
        ms_d  = {ms_q[ccts_pkg::SubW-2:0], ge3};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          o_secs_d    = secs_q;
          o_ms_d      = ms_q;
          o_us_d      = r3_q;
          o_total_d   = total_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      freq_q      <= ccts_pkg::FreqResetMhz;
      last_q      <= '0;
      wrap_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      freq_q      <= freq_d;
      last_q      <= last_d;
      wrap_q      <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cyc_q     <= cyc_d;
    total_q   <= total_d;
    secs_q    <= secs_d;
    r1_q      <= r1_d;
    r2_q      <= r2_d;
    r3_q      <= r3_d;
    ms_q      <= ms_d;
    o_secs_q  <= o_secs_d;
    o_ms_q    <= o_ms_d;
    o_us_q    <= o_us_d;
    o_total_q <= o_total_d;
  end

endmodule

>>> hdl/ccts_checker.sv
// port-level checks for the cycle count timestamp split unit, with bind
module ccts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ccts_pkg::SecW-1:0]     seconds_o,
  input logic [ccts_pkg::SubW-1:0]     milliseconds_o,
  input logic [ccts_pkg::SubW-1:0]     microseconds_o,
  input logic [ccts_pkg::CycleW-1:0]   total_microseconds_o
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(seconds_o)
      && $stable(milliseconds_o) && $stable(microseconds_o)
      && $stable(total_microseconds_o))
    else $error("result beat changed while stalled");

  // one beat in work at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in work");

  a_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> milliseconds_o <= ccts_pkg::SubMax)
    else $error("milliseconds out of range");

  a_us_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> microseconds_o <= ccts_pkg::SubMax)
    else $error("microseconds out of range");

endmodule

bind cycle_count_timestamp_split_unit ccts_checker u_ccts_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .seconds_o            (seconds_o),
  .milliseconds_o       (milliseconds_o),
  .microseconds_o       (microseconds_o),
  .total_microseconds_o (total_microseconds_o)
);

>>> test/ccts_stamp_checker.sv
// predicts the seconds / ms / us split of each sampled cycle count and compares result beats
module ccts_stamp_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [ccts_pkg::SampleW-1:0]        counter_sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [ccts_pkg::SecW-1:0]           seconds_i,
  input  logic [ccts_pkg::SubW-1:0]           milliseconds_i,
  input  logic [ccts_pkg::SubW-1:0]           microseconds_i,
  input  logic [ccts_pkg::CycleW-1:0]         total_microseconds_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [ccts_pkg::FreqW-1:0]          cpu_freq_mhz_i,
  output int unsigned                         fails_o,
  output int unsigned                         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ccts_pkg::SecW-1:0]   sec;
    logic [ccts_pkg::SubW-1:0]   ms;
    logic [ccts_pkg::SubW-1:0]   us;
    logic [ccts_pkg::CycleW-1:0] total_us;
  } stamp_t;

  logic [ccts_pkg::FreqW-1:0]   mhz_q         = ccts_pkg::FreqResetMhz;
  logic [ccts_pkg::SampleW-1:0] prev_sample_q = '0;
  logic [31:0]                  wraps_q       = '0;
  stamp_t                       expected_stamps[$];

  initial begin
    fails_o   = 0;
    pending_o = 0;
  end

  function automatic stamp_t split_cycle_count(input logic [ccts_pkg::CycleW-1:0] cycles,
                                               input logic [ccts_pkg::FreqW-1:0]  mhz);
    logic [ccts_pkg::CycleW-1:0] per_s, per_ms, per_us, secs, rem, ms, us;
    stamp_t                      st;
    per_us      = ccts_pkg::CycleW'(mhz);
    per_s       = per_us * ccts_pkg::CycleW'(ccts_pkg::UsPerS);
    per_ms      = per_us * ccts_pkg::CycleW'(ccts_pkg::UsPerMs);
    secs        = cycles / per_s;
    rem         = cycles - secs * per_s;
    ms          = rem / per_ms;
    rem         = rem - ms * per_ms;
    us          = rem / per_us;
    st.sec      = secs[ccts_pkg::SecW-1:0];
    st.ms       = ms[ccts_pkg::SubW-1:0];
    st.us       = us[ccts_pkg::SubW-1:0];
    st.total_us = secs * ccts_pkg::CycleW'(ccts_pkg::UsPerS)
                + ms * ccts_pkg::CycleW'(ccts_pkg::UsPerMs) + us;
    return st;
  endfunction

  always @(posedge clk_i) begin : track
    logic [31:0] wraps;
    stamp_t      want;
    stamp_t      got;
    if (!rst_ni) begin
      mhz_q         <= ccts_pkg::FreqResetMhz;
      prev_sample_q <= '0;
      wraps_q       <= '0;
      expected_stamps.delete();
    end else begin
      // a zero clock write is dropped
      if (cfg_valid_i && cfg_ready_i && cpu_freq_mhz_i != '0) begin
        mhz_q <= cpu_freq_mhz_i;
      end
      if (in_valid_i && in_ready_i) begin
        wraps = wraps_q + 32'(counter_sample_i < prev_sample_q);
        wraps_q       <= wraps;
        prev_sample_q <= counter_sample_i;
        expected_stamps.push_back(split_cycle_count({wraps, counter_sample_i}, mhz_q));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{seconds_i, milliseconds_i, microseconds_i, total_microseconds_i};
        if (expected_stamps.size() == 0) begin
          if (fails_o < 10) begin
            $display("%0t: result beat with nothing expected: sec=%0d ms=%0d us=%0d total=%0d",
                     $realtime, got.sec, got.ms, got.us, got.total_us);
          end
          fails_o++;
        end else begin
          want = expected_stamps.pop_front();
          if (got.sec !== want.sec || got.ms !== want.ms || got.us !== want.us ||
              got.total_us !== want.total_us) begin
            if (fails_o < 10) begin
              $display("%0t: mismatch expected sec=%0d ms=%0d us=%0d total=%0d", $realtime,
                       want.sec, want.ms, want.us, want.total_us);
              $display("%0t:          actual   sec=%0d ms=%0d us=%0d total=%0d", $realtime,
                       got.sec, got.ms, got.us, got.total_us);
            end
            fails_o++;
          end
        end
      end
    end
    pending_o = expected_stamps.size();
  end

endmodule

>>> test/cycle_count_timestamp_split_unit_tb.sv
// drives counter samples and clock settings into the timestamp split unit and gives the verdict
module cycle_count_timestamp_split_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned Latency    = 100;
  localparam int unsigned HoldCycles = 400;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic [ccts_pkg::SampleW-1:0]        counter_sample;
  logic                                out_valid;
  logic                                out_ready;
  logic [ccts_pkg::SecW-1:0]           seconds;
  logic [ccts_pkg::SubW-1:0]           milliseconds;
  logic [ccts_pkg::SubW-1:0]           microseconds;
  logic [ccts_pkg::CycleW-1:0]         total_microseconds;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [ccts_pkg::FreqW-1:0]          cfg_mhz;
  int unsigned                         fail_count;
  int unsigned                         pending_stamps;
  int unsigned                         cycles_run = 0;
  logic                                idle_on    = 1'b0;
  logic                                hold_req   = 1'b0;
  logic                                hold_done  = 1'b0;

  cycle_count_timestamp_split_unit dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .counter_sample_i     (counter_sample),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .seconds_o            (seconds),
    .milliseconds_o       (milliseconds),
    .microseconds_o       (microseconds),
    .total_microseconds_o (total_microseconds),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cpu_freq_mhz_i       (cfg_mhz)
  );

  ccts_stamp_checker checker_i (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .counter_sample_i     (counter_sample),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .seconds_i            (seconds),
    .milliseconds_i       (milliseconds),
    .microseconds_i       (microseconds),
    .total_microseconds_i (total_microseconds),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cpu_freq_mhz_i       (cfg_mhz),
    .fails_o              (fail_count),
    .pending_o            (pending_stamps)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CycleLimit) begin
      $display("FAIL cycle_count_timestamp_split_unit");
      $finish;
    end
  end

  // result side, with one long hold-off while samples keep coming
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_sample(input logic [ccts_pkg::SampleW-1:0] sample);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    counter_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_stamps != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
  endtask

  task automatic write_mhz(input logic [ccts_pkg::FreqW-1:0] mhz);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_mhz   <= mhz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ccts_pkg::SampleW-1:0] next_sample(
    input logic [ccts_pkg::SampleW-1:0] cur
  );
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return cur + ccts_pkg::SampleW'($urandom_range(2000));
    else if (pick < 72) return cur + ccts_pkg::SampleW'($urandom());
    else if (pick < 82) return cur;
    else if (pick < 90) return cur - ccts_pkg::SampleW'($urandom_range(1, 5000));
    else return ccts_pkg::SampleW'($urandom());
  endfunction

  initial begin : stimulus
    logic [ccts_pkg::SampleW-1:0] cur;
    logic [ccts_pkg::FreqW-1:0]   mhz;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    counter_sample = '0;
    cfg_valid      = 1'b0;
    cfg_mhz        = '0;
    cur            = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset clock setting, extremes, equal samples and wraps
    push_sample(32'h0000_0000);
    push_sample(32'h0000_0000);
    push_sample(32'h0000_0001);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h0000_0000);
    push_sample(32'h5555_5555);
    push_sample(32'hAAAA_AAAA);
    push_sample(32'd167_999_999);
    push_sample(32'd168_000_000);
    push_sample(32'd168_000_167);
    push_sample(32'd168_167_999);
    write_mhz(10'd1);
    push_sample(32'd999_999);
    push_sample(32'd1_000_000);
    write_mhz(10'd1023);
    push_sample(32'hFFFF_FFFF);
    write_mhz(10'd0);
    push_sample(32'd123);
    write_mhz(10'd1000);
    push_sample(32'd0);
    push_sample(32'd999_999_999);
    cur = 32'd999_999_999;

    for (int phase = 0; phase < 10; phase++) begin
      unique case (phase)
        0:       mhz = 10'd1;
        1:       mhz = 10'd1023;
        2:       mhz = 10'd1000;
        3:       mhz = 10'd0;
        default: mhz = ccts_pkg::FreqW'($urandom_range(1, 1023));
      endcase
      write_mhz(mhz);
      idle_on  <= (phase != 2);
      hold_req <= (phase == 4);
      for (int n = 0; n < 42; n++) begin
        if (phase == 6 && n == 20) drain_results();
        cur = next_sample(cur);
        push_sample(cur);
      end
    end

    drain_results();
    if (fail_count == 0 && pending_stamps == 0) begin
      $display("PASS cycle_count_timestamp_split_unit");
    end else begin
      $display("FAIL cycle_count_timestamp_split_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ccts_pkg.sv
hdl/cycle_count_timestamp_split_unit.sv
hdl/ccts_checker.sv
test/ccts_stamp_checker.sv
test/cycle_count_timestamp_split_unit_tb.sv
